/* rtl/lfwe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade engine package
// Shared widths, item kinds, fade directions and register indexes.
// ----------------------------------------------------------------------------
package lfwe_pkg;

	localparam int LEVEL_BITS_DEF = 8;
	localparam int PORT_LEVEL_BITS = 8;
	localparam int DUR_BITS = 16;
	localparam int KIND_BITS = 3;
	localparam int DIR_BITS = 2;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [DIR_BITS-1:0] dir_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam kind_t KIND_TICK = 3'd0;
	localparam kind_t KIND_FADE_LEVEL = 3'd1;
	localparam kind_t KIND_FADE_MAX = 3'd2;
	localparam kind_t KIND_FADE_MIN = 3'd3;
	localparam kind_t KIND_TOGGLE = 3'd4;
	localparam kind_t KIND_WAVE = 3'd5;

	localparam dir_t DIR_IDLE = 2'd0;
	localparam dir_t DIR_UP = 2'd1;
	localparam dir_t DIR_DOWN = 2'd2;

	localparam cfg_idx_t CFG_MIN_LEVEL = 2'd0;
	localparam cfg_idx_t CFG_MAX_LEVEL = 2'd1;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage
`default_nettype wire

/* rtl/lfwe_serial_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade engine serial divider
// Restoring divider that shifts in one dividend bit and produces one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module lfwe_serial_div #(
	parameter int DEND_BITS = 24,
	parameter int DSOR_BITS = lfwe_pkg::DUR_BITS
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire [DEND_BITS-1:0]   dividend,
	input  wire [DSOR_BITS-1:0]   divisor,
	output lfwe_pkg::div_ctl_t    status,
	output logic [DEND_BITS-1:0]  quotient
);

	localparam int CNT_BITS = $clog2(DEND_BITS + 1);

	logic [DSOR_BITS-1:0] rem_q;
	logic [DEND_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DSOR_BITS:0]   trial;
	logic [DSOR_BITS:0]   diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DEND_BITS-1]};
	assign diff = trial - {1'b0, divisor};
	assign fits = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(DEND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSOR_BITS-1:0] : trial[DSOR_BITS-1:0];
			quo_q <= {quo_q[DEND_BITS-2:0], fits};
		end
	end

	assign status.start = busy_q;
	assign status.done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/led_fade_wave_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED fade and wave engine
// Linear brightness fader with fade commands, toggle and repeating waves.
// ----------------------------------------------------------------------------
// Every accepted item gives one result. A command, or a tick while no fade
// is running, goes straight to the output state and enters the output
// register once the output slot is free. A tick during a fade passes through
// the load, divide, finish and output states, the bit-serial divider working
// out one quotient bit of full_scale * elapsed / duration per cycle. A tick
// during a fade with a zero duration skips the divider: load, finish, output.
// One item is worked on at a time; the next can be taken in the cycle after
// the previous result enters the output register, while that result may still
// wait there. The user must write the limit registers only while the block is
// idle; the block itself does not enforce this.
module led_fade_wave_engine #(
	parameter int LEVEL_BITS = lfwe_pkg::LEVEL_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [lfwe_pkg::KIND_BITS-1:0]       kind,
	input  wire  [lfwe_pkg::PORT_LEVEL_BITS-1:0] level,
	input  wire  [lfwe_pkg::DUR_BITS-1:0]        duration_ms,
	input  wire  [lfwe_pkg::DUR_BITS-1:0]        wave_count,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [lfwe_pkg::PORT_LEVEL_BITS-1:0] brightness,
	output logic [lfwe_pkg::DIR_BITS-1:0]        fade_state,
	output logic                                 waving,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [lfwe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire  [lfwe_pkg::PORT_LEVEL_BITS-1:0] cfg_data
);

	localparam int DW = lfwe_pkg::DUR_BITS;
	localparam int L = LEVEL_BITS;
	localparam int QW = L + DW;
	localparam logic [QW-1:0] FULL_Q = QW'((2 ** L) - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_FIN = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0]           state_q, n_state;
	logic [L-1:0]         min_q, max_q;
	logic [L-1:0]         cur_q, n_cur;
	lfwe_pkg::dir_t       dir_q, n_dir;
	logic [L-1:0]         start_q, n_start;
	logic [L-1:0]         target_q, n_target;
	logic [DW-1:0]        elapsed_q, n_elapsed;
	logic [DW-1:0]        dur_q, n_dur;
	logic [DW-1:0]        waves_q, n_waves;
	logic                 forever_q, n_forever;
	logic                 out_valid_q;
	logic [lfwe_pkg::PORT_LEVEL_BITS-1:0] bright_q;
	lfwe_pkg::dir_t       fstate_q;
	logic                 waving_q;

	logic                 do_fade;
	logic [L-1:0]         goal;
	logic [DW-1:0]        fade_dur;
	logic                 is_waving;
	logic                 slot_free;
	logic                 div_start;
	logic [QW-1:0]        dividend;
	logic [QW-1:0]        quotient;
	lfwe_pkg::div_ctl_t   div_status;
	logic [QW-1:0]        units;
	logic [QW:0]          up_next;
	logic [QW:0]          dn_next;
	logic [QW:0]          start_e, target_e, min_e, max_e;
	logic                 time_up;
	logic                 up_done;
	logic                 dn_done;
	logic [L-1:0]         level_in;

	assign is_waving = (waves_q != '0) || forever_q;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign level_in = L'(level);

	assign dividend = {elapsed_q, {L{1'b0}}} - QW'(elapsed_q);
	assign div_start = (state_q == ST_LOAD) && (dur_q != '0);

	lfwe_serial_div #(
		.DEND_BITS(QW),
		.DSOR_BITS(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dividend),
		.divisor(dur_q),
		.status(div_status),
		.quotient(quotient)
	);

	assign units = (dur_q == '0) ? FULL_Q : quotient;
	assign start_e = (QW + 1)'(start_q);
	assign target_e = (QW + 1)'(target_q);
	assign min_e = (QW + 1)'(min_q);
	assign max_e = (QW + 1)'(max_q);
	assign up_next = start_e + {1'b0, units};
	assign dn_next = start_e - {1'b0, units};
	assign time_up = elapsed_q >= dur_q;
	assign up_done = (up_next >= target_e) || time_up || (up_next >= max_e);
	assign dn_done = ({1'b0, units} > start_e) || (dn_next <= target_e) || time_up ||
		(dn_next <= min_e);

	always_comb begin
		n_state = state_q;
		n_cur = cur_q;
		n_dir = dir_q;
		n_start = start_q;
		n_target = target_q;
		n_elapsed = elapsed_q;
		n_dur = dur_q;
		n_waves = waves_q;
		n_forever = forever_q;
		do_fade = 1'b0;
		goal = max_q;
		fade_dur = duration_ms;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_state = ST_OUT;
					case (kind)
						lfwe_pkg::KIND_TICK: begin
							if (dir_q != lfwe_pkg::DIR_IDLE) begin
								if (elapsed_q != {DW{1'b1}}) begin
									n_elapsed = elapsed_q + 1'b1;
								end
								n_state = ST_LOAD;
							end
						end
						lfwe_pkg::KIND_FADE_LEVEL: begin
							do_fade = 1'b1;
							goal = level_in;
						end
						lfwe_pkg::KIND_FADE_MAX: begin
							do_fade = 1'b1;
							goal = max_q;
						end
						lfwe_pkg::KIND_FADE_MIN: begin
							do_fade = 1'b1;
							goal = min_q;
						end
						lfwe_pkg::KIND_TOGGLE: begin
							do_fade = 1'b1;
							goal = (cur_q > min_q) ? min_q : max_q;
						end
						lfwe_pkg::KIND_WAVE: begin
							do_fade = 1'b1;
							goal = max_q;
							n_forever = (wave_count == '0);
							n_waves = wave_count;
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOAD: begin
				n_state = (dur_q == '0) ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (div_status.done) begin
					n_state = ST_FIN;
				end
			end
			ST_FIN: begin
				n_state = ST_OUT;
				fade_dur = dur_q;
				case (dir_q)
					lfwe_pkg::DIR_UP: begin
						if (up_done) begin
							n_cur = target_q;
							n_dir = lfwe_pkg::DIR_IDLE;
							if (is_waving) begin
								do_fade = 1'b1;
								goal = min_q;
								if (waves_q != '0) begin
									n_waves = waves_q - 1'b1;
								end
							end
						end else begin
							n_cur = up_next[L-1:0];
						end
					end
					lfwe_pkg::DIR_DOWN: begin
						if (dn_done) begin
							n_cur = target_q;
							n_dir = lfwe_pkg::DIR_IDLE;
							if (is_waving) begin
								do_fade = 1'b1;
								goal = max_q;
							end
						end else begin
							n_cur = dn_next[L-1:0];
						end
					end
					default: begin
						n_dir = lfwe_pkg::DIR_IDLE;
					end
				endcase
			end
			ST_OUT: begin
				if (slot_free) begin
					n_state = ST_IDLE;
				end
			end
			default: begin
				n_state = ST_IDLE;
			end
		endcase
		if (do_fade) begin
			if (goal == n_cur) begin
				n_dir = lfwe_pkg::DIR_IDLE;
			end else begin
				n_dir = (goal > n_cur) ? lfwe_pkg::DIR_UP : lfwe_pkg::DIR_DOWN;
				n_start = n_cur;
				n_target = goal;
				n_elapsed = '0;
				n_dur = fade_dur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q <= '0;
			max_q <= L'(8'd255);
			cur_q <= '0;
			dir_q <= lfwe_pkg::DIR_IDLE;
			start_q <= '0;
			target_q <= '0;
			elapsed_q <= '0;
			dur_q <= '0;
			waves_q <= '0;
			forever_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= n_state;
			cur_q <= n_cur;
			dir_q <= n_dir;
			start_q <= n_start;
			target_q <= n_target;
			elapsed_q <= n_elapsed;
			dur_q <= n_dur;
			waves_q <= n_waves;
			forever_q <= n_forever;
			if (cfg_valid && (cfg_index == lfwe_pkg::CFG_MIN_LEVEL)) begin
				min_q <= L'(cfg_data);
			end
			if (cfg_valid && (cfg_index == lfwe_pkg::CFG_MAX_LEVEL)) begin
				max_q <= L'(cfg_data);
			end
			if ((state_q == ST_OUT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && slot_free) begin
			bright_q <= lfwe_pkg::PORT_LEVEL_BITS'(cur_q);
			fstate_q <= dir_q;
			waving_q <= is_waving;
		end
	end

	assign out_valid = out_valid_q;
	assign brightness = bright_q;
	assign fade_state = fstate_q;
	assign waving = waving_q;

endmodule
`default_nettype wire
